[hdl/spq_pkg.sv]
// ---------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue, its cells, its
// channel interfaces and its checker.
// ---------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   // payload widths fixed by the item format
   localparam int DATA_W       = 32;
   localparam int COUNT_W      = 5;
   localparam int DEF_CAPACITY = 16;

   // queue operations
   typedef enum logic [1:0] {
      OP_PUSH     = 2'd0,
      OP_POP      = 2'd1,
      OP_REMOVE   = 2'd2,
      OP_CONTAINS = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // what every cell does in the apply cycle
   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_POP    = 2'd2,
      CMD_DELETE = 2'd3
   } cell_cmd_type;

   // broadcast from the controller to the row of cells
   typedef struct packed {
      logic                     probe;
      cell_cmd_type             cmd;
      logic signed [DATA_W-1:0] value;
   } cell_ctl_type;

endpackage : spq_pkg

`default_nettype wire

[hdl/spq_req_if.sv]
// ---------------------------------------------------------------------------
// spq_req_if
// Request channel of the priority queue: opcode and value with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface spq_req_if;
   logic                             valid;
   logic                             ready;
   spq_pkg::op_type                  opcode;
   logic signed [spq_pkg::DATA_W-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface : spq_req_if

`default_nettype wire

[hdl/spq_rsp_if.sv]
// ---------------------------------------------------------------------------
// spq_rsp_if
// Response channel of the priority queue: one result item per request item.
// ---------------------------------------------------------------------------
`default_nettype none

interface spq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [spq_pkg::DATA_W-1:0]  popped_value;
   spq_pkg::status_type                status;
   logic                               found;
   logic [spq_pkg::COUNT_W-1:0]        count;

   modport source (output valid, output popped_value, output status, output found,
                   output count, input ready);
   modport sink   (input valid, input popped_value, input status, input found,
                   input count, output ready);
endinterface : spq_rsp_if

`default_nettype wire

[hdl/spq_cell.sv]
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry and its occupancy, compares it
// against the broadcast value, and shifts toward either neighbor on command.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_cell (
   input  wire                                clock,
   input  wire                                reset,
   input  wire spq_pkg::cell_ctl_type         ctl,
   input  wire logic signed [spq_pkg::DATA_W-1:0] left_value,
   input  wire                                left_valid,
   input  wire                                left_ins,
   input  wire logic signed [spq_pkg::DATA_W-1:0] right_value,
   input  wire                                right_valid,
   output logic signed [spq_pkg::DATA_W-1:0]  value_out,
   output logic                               valid_out,
   output logic                               ins_out,
   output logic                               eq_out
);

   logic signed [spq_pkg::DATA_W-1:0] value_ff, value_in;
   logic                              valid_ff, valid_in;
   logic                              ins_ff, ins_in;
   logic                              eq_ff, eq_in;

   // probe: is this slot at or past the place of the value, does it match
   always_comb begin
      ins_in = ins_ff;
      eq_in  = eq_ff;
      if (ctl.probe) begin
         ins_in = !(valid_ff && (value_ff > ctl.value));
         eq_in  = valid_ff && (value_ff == ctl.value);
      end
   end

   // apply: shift right for insert, shift left for pop and delete
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (ctl.cmd)
         spq_pkg::CMD_INSERT: begin
            if (left_ins) begin
               value_in = left_value;
               valid_in = left_valid;
            end else if (ins_ff) begin
               value_in = ctl.value;
               valid_in = 1'b1;
            end
         end
         spq_pkg::CMD_POP: begin
            value_in = right_value;
            valid_in = right_valid;
         end
         spq_pkg::CMD_DELETE: begin
            if (ins_ff) begin
               value_in = right_value;
               valid_in = right_valid;
            end
         end
         default: begin
            value_in = value_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   // entry storage
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // occupancy and probe flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ins_ff   <= 1'b0;
         eq_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         ins_ff   <= ins_in;
         eq_ff    <= eq_in;
      end
   end

   assign value_out = value_ff;
   assign valid_out = valid_ff;
   assign ins_out   = ins_ff;
   assign eq_out    = eq_ff;

endmodule : spq_cell

`default_nettype wire

[hdl/sorted_priority_queue.sv]
// ---------------------------------------------------------------------------
// sorted_priority_queue
// Bounded max-first priority queue of signed 32-bit values, held sorted in a
// row of compare-and-shift cells.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one operation per item: push, pop largest, remove one
//   copy of a value, or a contains query. rsp_chan returns exactly one result
//   item per request: popped value, status, found flag and the entry count.
//   Per item: in the accept cycle every cell compares its
//   entry with the value; in the next cycle the controller ORs the match
//   flags of the row and the cells shift at once where the operation changes
//   the row. The result is registered and appears on rsp_chan the cycle after
//   that; a new item is taken only once the previous one is applied, and only
//   while results are drained.
//   The result register decouples the sides: a new item is taken while the
//   previous result is being taken in the same cycle. If the receiver stalls,
//   the result holds and req_chan.ready stays low until it is taken.
//   Reset empties every cell and clears the count at once; no clearing
//   pass is run.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
   input wire        clock,
   input wire        reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type                         state_ff, state_in;
   spq_pkg::op_type                   op_ff, op_in;
   logic signed [spq_pkg::DATA_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [spq_pkg::DATA_W-1:0] popped_ff, popped_in;
   spq_pkg::status_type               status_ff, status_in;
   logic                              found_ff, found_in;

   spq_pkg::cell_ctl_type             ctl;
   spq_pkg::cell_cmd_type             cmd;
   logic                              accept;
   logic                              any_match;
   logic                              full;
   logic                              empty;

   logic signed [spq_pkg::DATA_W-1:0] cell_value [CAPACITY];
   logic                              cell_valid [CAPACITY];
   logic                              cell_ins   [CAPACITY];
   logic [CAPACITY-1:0]               cell_eq;

   // handshake
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   // row status
   assign any_match = |cell_eq;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   // broadcast to the cells
   always_comb begin
      ctl.probe = accept;
      ctl.cmd   = cmd;
      ctl.value = accept ? req_chan.value : value_ff;
   end

   // row of cells
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [spq_pkg::DATA_W-1:0] lv, rv;
      logic                              lval, lins, rval;
      if (g == 0) begin : g_head
         assign lv   = '0;
         assign lval = 1'b0;
         assign lins = 1'b0;
      end else begin : g_mid
         assign lv   = cell_value[g-1];
         assign lval = cell_valid[g-1];
         assign lins = cell_ins[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign rv   = cell_value[g];
         assign rval = 1'b0;
      end else begin : g_body
         assign rv   = cell_value[g+1];
         assign rval = cell_valid[g+1];
      end
      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_value  (lv),
         .left_valid  (lval),
         .left_ins    (lins),
         .right_value (rv),
         .right_valid (rval),
         .value_out   (cell_value[g]),
         .valid_out   (cell_valid[g]),
         .ins_out     (cell_ins[g]),
         .eq_out      (cell_eq[g])
      );
   end

   // operation decode in the apply cycle
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      popped_in    = popped_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      cmd          = spq_pkg::CMD_HOLD;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_chan.opcode;
               value_in = req_chan.value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            popped_in    = '0;
            status_in    = spq_pkg::ST_OK;
            found_in     = 1'b0;
            case (op_ff)
               spq_pkg::OP_PUSH: begin
                  if (full) begin
                     status_in = spq_pkg::ST_FULL;
                  end else begin
                     cmd      = spq_pkg::CMD_INSERT;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               spq_pkg::OP_POP: begin
                  if (empty) begin
                     status_in = spq_pkg::ST_EMPTY;
                  end else begin
                     cmd       = spq_pkg::CMD_POP;
                     popped_in = cell_value[0];
                     count_in  = count_ff - CNT_W'(1);
                  end
               end
               spq_pkg::OP_REMOVE: begin
                  if (any_match) begin
                     cmd      = spq_pkg::CMD_DELETE;
                     found_in = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     status_in = spq_pkg::ST_NOT_FOUND;
                  end
               end
               default: begin
                  if (any_match) begin
                     found_in = 1'b1;
                  end else begin
                     status_in = spq_pkg::ST_NOT_FOUND;
                  end
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      value_ff  <= value_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   // result channel
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.popped_value = popped_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.found        = found_ff;
   assign rsp_chan.count        = spq_pkg::COUNT_W'(count_ff);

endmodule : sorted_priority_queue

`default_nettype wire

[hdl/spq_checker.sv]
// ---------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_checker #(
   parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 rsp_valid,
   input wire                                 rsp_ready,
   input wire logic signed [spq_pkg::DATA_W-1:0] rsp_popped_value,
   input wire logic [1:0]                     rsp_status,
   input wire                                 rsp_found,
   input wire logic [spq_pkg::COUNT_W-1:0]    rsp_count
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_popped_value)
         && $stable(rsp_status) && $stable(rsp_found) && $stable(rsp_count))
      else $error("result item changed while stalled");

   // count stays within the capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_count) <= CAPACITY))
      else $error("count above capacity");

   // empty pop leaves nothing and returns zero
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == spq_pkg::ST_EMPTY) |->
         (rsp_popped_value == '0) && !rsp_found && (rsp_count == '0))
      else $error("empty status with data or nonzero count");

   // full push reports the capacity
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == spq_pkg::ST_FULL) |->
         (rsp_count == spq_pkg::COUNT_W'(CAPACITY)) && !rsp_found)
      else $error("full status with count below capacity");

   // found only goes with an ok status and no popped data
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |->
         (rsp_status == spq_pkg::ST_OK) && (rsp_popped_value == '0))
      else $error("found flag with bad status or popped data");

endmodule : spq_checker

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_popped_value (rsp_chan.popped_value),
   .rsp_status       (rsp_chan.status),
   .rsp_found        (rsp_chan.found),
   .rsp_count        (rsp_chan.count)
);

`default_nettype wire
